@@ design/cfpf_pkg.sv @@
// ----------------------------------------------------------------------------
// cfpf_pkg
// Shared types and constants of the clipped fill planar frame buffer:
// command kinds, the clipped command record and the queue depth.
// ----------------------------------------------------------------------------
package cfpf_pkg;

    // default screen size
    localparam int SCREEN_W_DEF = 640;
    localparam int SCREEN_H_DEF = 480;

    // coordinate width covers 0..2047
    localparam int COORD_W = 11;
    // word column: eight pixels per memory word
    localparam int WCOL_W  = COORD_W - 3;

    // pixel storage
    localparam int PIX_W   = 4;
    localparam int LANES   = 8;
    localparam int WORD_W  = PIX_W * LANES;

    // input payload layout
    localparam int KIND_W     = 3;
    localparam int COLOR_W    = 8;
    localparam int PLANE_W    = 2;
    localparam int BCOL_W     = 7;
    localparam int IN_FIELDS  = 5 * 16 + COLOR_W + PLANE_W + BCOL_W;
    localparam int IN_DATA_W  = ((IN_FIELDS + 7) / 8) * 8;
    localparam int OUT_DATA_W = 8;

    // command queue depth between front and back
    localparam int QDEPTH   = 4;
    localparam int QPTR_W   = $clog2(QDEPTH);

    // command kinds as seen on the input stream
    typedef enum logic [KIND_W-1:0] {
        K_CLEAR = 3'd0,
        K_PIXEL = 3'd1,
        K_RECT  = 3'd2,
        K_VLINE = 3'd3,
        K_READ  = 3'd4
    } t_kind;

    // operations handed to the back end
    typedef enum logic {
        OP_FILL = 1'b0,
        OP_READ = 1'b1
    } t_op;

    // clipped command: fill covers [x0,x1) x [y0,y1); read uses y0, bcol, plane
    typedef struct packed {
        t_op                op;
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] y1;
        logic [PIX_W-1:0]   color;
        logic [PLANE_W-1:0] plane;
        logic [BCOL_W-1:0]  bcol;
        logic               rd_ok;
    } t_cmd;

    // handshake between queue and back end
    typedef struct packed {
        logic valid;
        t_cmd cmd;
    } t_qout;

endpackage

@@ design/cfpf_front.sv @@
// ----------------------------------------------------------------------------
// cfpf_front
// Input stage: registers one command, clips it against the screen and turns
// it into a fill span or a plane read. Empty and unknown commands are dropped.
// ----------------------------------------------------------------------------
module cfpf_front #(
    parameter int SCREEN_W = cfpf_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = cfpf_pkg::SCREEN_H_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic [cfpf_pkg::KIND_W-1:0]      i_kind,
    input  logic [cfpf_pkg::IN_DATA_W-1:0]   i_data,
    output logic                             o_push,
    input  logic                             i_full,
    output cfpf_pkg::t_cmd                   o_cmd
);

    localparam int CW = cfpf_pkg::COORD_W;
    localparam int RD_COLS = SCREEN_W / 8;
    localparam logic signed [16:0] W17 = 17'(SCREEN_W);
    localparam logic signed [16:0] H17 = 17'(SCREEN_H);

    logic                           r_vld;
    logic [cfpf_pkg::KIND_W-1:0]    r_kind;
    logic [cfpf_pkg::IN_DATA_W-1:0] r_data;
    logic                           n_vld;

    logic signed [15:0] f_x, f_y, f_w, f_h, f_ye;
    logic [cfpf_pkg::COLOR_W-1:0] f_color;
    logic [cfpf_pkg::PLANE_W-1:0] f_plane;
    logic [cfpf_pkg::BCOL_W-1:0]  f_bcol;

    logic signed [16:0] s_x, s_y, s_ye, s_xe, s_yb;
    logic signed [16:0] c_x0, c_x1, c_y0, c_y1;
    logic               x_in, y_in, keep, consume;

    // unpack fields, lowest first
    assign f_x     = r_data[15:0];
    assign f_y     = r_data[31:16];
    assign f_w     = r_data[47:32];
    assign f_h     = r_data[63:48];
    assign f_ye    = r_data[79:64];
    assign f_color = r_data[87:80];
    assign f_plane = r_data[89:88];
    assign f_bcol  = r_data[96:90];

    assign s_x  = {f_x[15], f_x};
    assign s_y  = {f_y[15], f_y};
    assign s_ye = {f_ye[15], f_ye};
    assign s_xe = s_x + {f_w[15], f_w};
    assign s_yb = s_y + {f_h[15], f_h};

    assign x_in = !f_x[15] && (s_x < W17);
    assign y_in = !f_y[15] && (s_y < H17);

    // clip each kind to a half-open span
    always_comb begin
        c_x0 = '0;
        c_x1 = '0;
        c_y0 = '0;
        c_y1 = '0;
        keep = 1'b0;
        o_cmd       = '0;
        o_cmd.color = f_color[cfpf_pkg::PIX_W-1:0];
        o_cmd.plane = f_plane;
        o_cmd.bcol  = f_bcol;
        o_cmd.op    = cfpf_pkg::OP_FILL;
        unique case (cfpf_pkg::t_kind'(r_kind))
            cfpf_pkg::K_CLEAR: begin
                c_x1 = W17;
                c_y1 = H17;
                keep = 1'b1;
            end
            cfpf_pkg::K_PIXEL: begin
                c_x0 = s_x;
                c_x1 = s_x + 17'sd1;
                c_y0 = s_y;
                c_y1 = s_y + 17'sd1;
                keep = x_in && y_in;
            end
            cfpf_pkg::K_RECT: begin
                c_x0 = f_x[15] ? 17'sd0 : s_x;
                c_x1 = (s_xe > W17) ? W17 : s_xe;
                c_y0 = f_y[15] ? 17'sd0 : s_y;
                c_y1 = (s_yb > H17) ? H17 : s_yb;
                keep = (c_x1 > c_x0) && (c_y1 > c_y0);
            end
            cfpf_pkg::K_VLINE: begin
                c_x0 = s_x;
                c_x1 = s_x + 17'sd1;
                c_y0 = f_y[15] ? 17'sd0 : s_y;
                c_y1 = (s_ye > H17) ? H17 : s_ye;
                keep = x_in && (c_y1 > c_y0);
            end
            cfpf_pkg::K_READ: begin
                c_y0 = s_y;
                keep = 1'b1;
                o_cmd.op = cfpf_pkg::OP_READ;
            end
            default: keep = 1'b0;
        endcase
        o_cmd.x0    = CW'(c_x0);
        o_cmd.x1    = CW'(c_x1);
        o_cmd.y0    = CW'(c_y0);
        o_cmd.y1    = CW'(c_y1);
        o_cmd.rd_ok = y_in && ({1'b0, f_bcol} < 8'(RD_COLS));
    end

    // a held command leaves when the queue has room or when it is dropped
    assign o_push  = r_vld && keep && !i_full;
    assign consume = r_vld && (!keep || !i_full);
    assign o_ready = !r_vld || consume;

    always_comb begin
        n_vld = r_vld;
        if (i_valid && o_ready) begin
            n_vld = 1'b1;
        end else if (consume) begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // input payload capture
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_kind <= i_kind;
            r_data <= i_data;
        end
    end

endmodule

@@ design/cfpf_queue.sv @@
// ----------------------------------------------------------------------------
// cfpf_queue
// Short first-in first-out queue of clipped commands between the front
// and the back end.
// ----------------------------------------------------------------------------
module cfpf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  cfpf_pkg::t_cmd  i_cmd,
    output logic            o_full,
    output cfpf_pkg::t_qout o_q,
    input  logic            i_pop
);

    localparam int PW = cfpf_pkg::QPTR_W;

    cfpf_pkg::t_cmd r_mem [cfpf_pkg::QDEPTH];
    logic [PW-1:0]  r_wptr, r_rptr, n_wptr, n_rptr;
    logic [PW:0]    r_cnt, n_cnt;
    logic           do_push, do_pop;

    assign o_full   = (r_cnt == (PW+1)'(cfpf_pkg::QDEPTH));
    assign o_q.valid = (r_cnt != '0);
    assign o_q.cmd   = r_mem[r_rptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_q.valid;

    // pointer and fill count update
    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

endmodule

@@ design/cfpf_back.sv @@
// ----------------------------------------------------------------------------
// cfpf_back
// Drawing engine and frame store: walks fill spans one memory word (eight
// pixels) per cycle with per-pixel write enables, and serves plane reads
// into the output register.
// ----------------------------------------------------------------------------
module cfpf_back #(
    parameter int SCREEN_W = cfpf_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = cfpf_pkg::SCREEN_H_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  cfpf_pkg::t_qout                   i_q,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [cfpf_pkg::OUT_DATA_W-1:0]   o_data
);

    localparam int CW    = cfpf_pkg::COORD_W;
    localparam int WCW   = cfpf_pkg::WCOL_W;
    localparam int PW    = cfpf_pkg::PIX_W;
    localparam int LN    = cfpf_pkg::LANES;
    localparam int WB    = (SCREEN_W + 7) / 8;
    localparam int DEPTH = SCREEN_H * WB;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FILL  = 4'b0010,
        S_RADDR = 4'b0100,
        S_RDATA = 4'b1000
    } t_state;

    t_state r_state, n_state;

    logic [cfpf_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [cfpf_pkg::WORD_W-1:0] r_rdata;

    logic [CW-1:0]  r_x0, r_x1, r_row, r_y1, n_row;
    logic [WCW-1:0] r_wc, r_wc_first, r_wc_last, n_wc;
    logic [AW-1:0]  r_row_base, n_row_base, r_addr;
    logic [PW-1:0]  r_color;
    logic [cfpf_pkg::PLANE_W-1:0] r_plane;
    logic           r_rd_ok;
    logic           r_out_valid, n_out_valid;
    logic [cfpf_pkg::OUT_DATA_W-1:0] r_out_data, gather;

    logic [AW-1:0]  head_base, wr_addr;
    logic [CW-1:0]  x1_m1, pix;
    logic [LN-1:0]  lane_en;
    logic [PW-1:0]  nib;
    logic           wr_en, rd_en, load_out, row_done, last_row;

    // row start address of the head command
    assign head_base = AW'(32'(i_q.cmd.y0) * WB);
    assign x1_m1     = i_q.cmd.x1 - 1'b1;

    assign o_pop    = (r_state == S_IDLE) && i_q.valid;
    assign wr_en    = (r_state == S_FILL);
    assign rd_en    = (r_state == S_RADDR) && r_rd_ok;
    assign load_out = (r_state == S_RDATA) && (!r_out_valid || i_ready);
    assign wr_addr  = r_row_base + AW'(r_wc);
    assign row_done = (r_wc == r_wc_last);
    assign last_row = (r_row + 1'b1 == r_y1);

    // pixel write enables within the current word
    always_comb begin
        pix = '0;
        for (int i = 0; i < LN; i++) begin
            pix = {r_wc, 3'(i)};
            lane_en[i] = (pix >= r_x0) && (pix < r_x1);
        end
    end

    // pick one plane bit of each pixel, leftmost pixel in the top bit
    always_comb begin
        nib = '0;
        gather = '0;
        for (int i = 0; i < LN; i++) begin
            nib = r_rdata[PW*i +: PW];
            gather[LN-1-i] = nib[r_plane];
        end
    end

    // sequencer next state and span walk
    always_comb begin
        n_state    = r_state;
        n_row      = r_row;
        n_wc       = r_wc;
        n_row_base = r_row_base;
        unique case (r_state)
            S_IDLE: begin
                if (i_q.valid) begin
                    n_row      = i_q.cmd.y0;
                    n_wc       = i_q.cmd.x0[CW-1:3];
                    n_row_base = head_base;
                    n_state    = (i_q.cmd.op == cfpf_pkg::OP_FILL) ? S_FILL : S_RADDR;
                end
            end
            S_FILL: begin
                if (!row_done) begin
                    n_wc = r_wc + 1'b1;
                end else if (!last_row) begin
                    n_wc       = r_wc_first;
                    n_row      = r_row + 1'b1;
                    n_row_base = r_row_base + AW'(WB);
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_RADDR: n_state = S_RDATA;
            S_RDATA: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register valid
    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // span and read operands
    always_ff @(posedge i_clk) begin
        r_row      <= n_row;
        r_wc       <= n_wc;
        r_row_base <= n_row_base;
        if (o_pop) begin
            r_x0       <= i_q.cmd.x0;
            r_x1       <= i_q.cmd.x1;
            r_y1       <= i_q.cmd.y1;
            r_wc_first <= i_q.cmd.x0[CW-1:3];
            r_wc_last  <= x1_m1[CW-1:3];
            r_color    <= i_q.cmd.color;
            r_plane    <= i_q.cmd.plane;
            r_rd_ok    <= i_q.cmd.rd_ok;
            r_addr     <= head_base + AW'(i_q.cmd.bcol);
        end
        if (load_out) begin
            r_out_data <= r_rd_ok ? gather : '0;
        end
    end

    // frame store: one masked word write and one registered word read
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < LN; i++) begin
            if (wr_en && lane_en[i]) begin
                r_mem[wr_addr][PW*i +: PW] <= r_color;
            end
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_addr];
        end
    end

    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;

endmodule

@@ design/clipped_fill_planar_framebuffer.sv @@
// ----------------------------------------------------------------------------
// clipped_fill_planar_framebuffer
// 4-bit-per-pixel frame store with clipped clear, pixel, rectangle and column
// fills, and a planar byte read port.
//
//  channel  | dir | tuser       | tdata (lowest bit first)
//  ---------+-----+-------------+-----------------------------------------
//  s_axis   | in  | kind [2:0]  | x, y, w, h, y_end, color, plane, byte_col
//  m_axis   | out | -           | plane_byte [7:0]
//
// A read goes through the input register, the command queue, and the read
// address and data states of the engine into the output register; a fill
// writes one eight-pixel memory word per cycle, row by row. The single
// frame store write port sets the fill rate. Reset clears control only:
// the store holds garbage until a clear. A four-entry command queue lets
// input continue while a fill runs or a result waits.
// ----------------------------------------------------------------------------
module clipped_fill_planar_framebuffer #(
    parameter int SCREEN_W = cfpf_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = cfpf_pkg::SCREEN_H_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // kind [2:0]
    input  logic [cfpf_pkg::KIND_W-1:0]       i_s_axis_tuser,
    // x [15:0], y [31:16], w [47:32], h [63:48], y_end [79:64],
    // color [87:80], plane [89:88], byte_col [96:90], zero [103:97]
    input  logic [cfpf_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // plane_byte [7:0]
    output logic [cfpf_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    logic            push, full, pop;
    cfpf_pkg::t_cmd  cmd;
    cfpf_pkg::t_qout qout;

    // command clipping
    cfpf_front #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_kind  (i_s_axis_tuser),
        .i_data  (i_s_axis_tdata),
        .o_push  (push),
        .i_full  (full),
        .o_cmd   (cmd)
    );

    // command queue
    cfpf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .o_full  (full),
        .o_q     (qout),
        .i_pop   (pop)
    );

    // drawing engine and store
    cfpf_back #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_q     (qout),
        .o_pop   (pop),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_data  (o_m_axis_tdata)
    );

endmodule

@@ design/cfpf_checker.sv @@
// ----------------------------------------------------------------------------
// cfpf_checker
// Port-level checks of the frame buffer: reset behavior and the result
// stream holding under backpressure.
// ----------------------------------------------------------------------------
module cfpf_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              o_s_axis_tready,
    input logic                              o_m_axis_tvalid,
    input logic                              i_m_axis_tready,
    input logic [cfpf_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata
);

    // no result is offered right after reset
    a_no_out_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result offered right after reset");

    // the input stage is empty right after reset
    a_ready_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready)
        else $error("input not ready right after reset");

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    // a stalled result keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

endmodule

bind clipped_fill_planar_framebuffer cfpf_checker u_cfpf_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ sim/cfpf_plane_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cfpf_plane_checker
// Watches both streams of the frame buffer. Keeps a shadow copy of the
// frame store, updated by every accepted draw command, and compares each
// returned plane byte with the byte gathered from the shadow.
// ----------------------------------------------------------------------------
module cfpf_plane_checker #(
    parameter int SCREEN_W = cfpf_pkg::SCREEN_W_DEF,
    parameter int SCREEN_H = cfpf_pkg::SCREEN_H_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    input  logic                            i_s_axis_tready,
    // kind [2:0]
    input  logic [cfpf_pkg::KIND_W-1:0]     i_s_axis_tuser,
    // x [15:0], y [31:16], w [47:32], h [63:48], y_end [79:64],
    // color [87:80], plane [89:88], byte_col [96:90], zero [103:97]
    input  logic [cfpf_pkg::IN_DATA_W-1:0]  i_s_axis_tdata,
    input  logic                            i_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // plane_byte [7:0]
    input  logic [cfpf_pkg::OUT_DATA_W-1:0] i_m_axis_tdata,
    output int                              o_fail_count,
    output int                              o_reads_pending
);

    localparam int KIND_W     = cfpf_pkg::KIND_W;
    localparam int IN_DATA_W  = cfpf_pkg::IN_DATA_W;
    localparam int OUT_DATA_W = cfpf_pkg::OUT_DATA_W;
    localparam int PIX_W      = cfpf_pkg::PIX_W;
    localparam int LANES      = cfpf_pkg::LANES;
    localparam int PLANE_W    = cfpf_pkg::PLANE_W;
    localparam int BCOL_W     = cfpf_pkg::BCOL_W;
    localparam int BYTE_COLS  = SCREEN_W / LANES;

    // field positions in the command word
    localparam int POS_X     = 0;
    localparam int POS_Y     = 16;
    localparam int POS_W     = 32;
    localparam int POS_H     = 48;
    localparam int POS_YE    = 64;
    localparam int POS_COLOR = 80;
    localparam int POS_PLANE = 88;
    localparam int POS_BCOL  = 90;

    logic [PIX_W-1:0]      frame_shadow [SCREEN_W*SCREEN_H];
    logic [OUT_DATA_W-1:0] plane_bytes_due [$];
    logic [OUT_DATA_W-1:0] due_byte;
    int                    mismatches = 0;

    // paint the half-open box [x0,x1) x [y0,y1)
    function automatic void shadow_fill(int x0, int y0, int x1, int y1,
                                        logic [PIX_W-1:0] c);
        for (int r = y0; r < y1; r++)
            for (int k = x0; k < x1; k++)
                frame_shadow[r*SCREEN_W + k] = c;
    endfunction

    // one plane of eight pixels, leftmost pixel in the top bit
    function automatic logic [OUT_DATA_W-1:0] shadow_plane_byte(int row, int bcol,
                                                               int plane);
        logic [OUT_DATA_W-1:0] b;
        b = '0;
        if (row >= 0 && row < SCREEN_H && bcol < BYTE_COLS)
            for (int i = 0; i < LANES; i++)
                b[LANES-1-i] = frame_shadow[row*SCREEN_W + bcol*LANES + i][plane];
        return b;
    endfunction

    // apply one accepted command to the shadow store
    function automatic void shadow_command(logic [KIND_W-1:0] kind,
                                           logic [IN_DATA_W-1:0] d);
        int               x, y, w, h, ye;
        logic [PIX_W-1:0] c;
        x  = $signed(d[POS_X +: 16]);
        y  = $signed(d[POS_Y +: 16]);
        w  = $signed(d[POS_W +: 16]);
        h  = $signed(d[POS_H +: 16]);
        ye = $signed(d[POS_YE +: 16]);
        c  = d[POS_COLOR +: PIX_W];
        case (kind)
            cfpf_pkg::K_CLEAR: shadow_fill(0, 0, SCREEN_W, SCREEN_H, c);
            cfpf_pkg::K_PIXEL: begin
                if (x >= 0 && x < SCREEN_W && y >= 0 && y < SCREEN_H)
                    frame_shadow[y*SCREEN_W + x] = c;
            end
            cfpf_pkg::K_RECT: begin
                // pull a negative origin onto the screen, then cut the far edges
                if (x < 0) begin
                    w = w + x;
                    x = 0;
                end
                if (y < 0) begin
                    h = h + y;
                    y = 0;
                end
                if (x + w > SCREEN_W) w = SCREEN_W - x;
                if (y + h > SCREEN_H) h = SCREEN_H - y;
                if (w > 0 && h > 0) shadow_fill(x, y, x + w, y + h, c);
            end
            cfpf_pkg::K_VLINE: begin
                if (x >= 0 && x < SCREEN_W) begin
                    if (y < 0) y = 0;
                    if (ye > SCREEN_H) ye = SCREEN_H;
                    if (ye > y) shadow_fill(x, y, x + 1, ye, c);
                end
            end
            cfpf_pkg::K_READ: begin
                plane_bytes_due.push_back(shadow_plane_byte(y,
                    int'(d[POS_BCOL +: BCOL_W]), int'(d[POS_PLANE +: PLANE_W])));
            end
            default: ;
        endcase
    endfunction

    // result check first, then the command of the same edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            plane_bytes_due.delete();
            o_reads_pending <= 0;
        end else begin
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (plane_bytes_due.size() == 0) begin
                    $error("plane_byte: transfer with no read waiting, actual %02h",
                           i_m_axis_tdata);
                    mismatches++;
                end else begin
                    due_byte = plane_bytes_due.pop_front();
                    if (due_byte !== i_m_axis_tdata) begin
                        $error("plane_byte: expected %02h, actual %02h",
                               due_byte, i_m_axis_tdata);
                        mismatches++;
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready)
                shadow_command(i_s_axis_tuser, i_s_axis_tdata);
            o_reads_pending <= plane_bytes_due.size();
        end
        o_fail_count <= mismatches;
    end

endmodule

@@ sim/tb_clipped_fill_planar_framebuffer.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_clipped_fill_planar_framebuffer
// Drives clear, pixel, rectangle, column fill and plane read commands into
// the frame buffer with bursty input and a stalling result side, and lets
// the plane checker compare every returned byte against its shadow store.
// ----------------------------------------------------------------------------
module tb_clipped_fill_planar_framebuffer;

    localparam int KIND_W         = cfpf_pkg::KIND_W;
    localparam int IN_DATA_W      = cfpf_pkg::IN_DATA_W;
    localparam int IN_FIELDS      = cfpf_pkg::IN_FIELDS;
    localparam int OUT_DATA_W     = cfpf_pkg::OUT_DATA_W;
    localparam int COLOR_W        = cfpf_pkg::COLOR_W;
    localparam int PLANE_W        = cfpf_pkg::PLANE_W;
    localparam int BCOL_W         = cfpf_pkg::BCOL_W;
    localparam int LANES          = cfpf_pkg::LANES;
    localparam int SCREEN_W       = cfpf_pkg::SCREEN_W_DEF;
    localparam int SCREEN_H       = cfpf_pkg::SCREEN_H_DEF;
    localparam int BYTE_COLS      = SCREEN_W / LANES;
    localparam int BCOL_MAX       = (1 << BCOL_W) - 1;
    localparam int RESET_CYCLES   = 5;
    localparam int RANDOM_ITEMS   = 967;
    localparam int BIG_FILL_EVERY = 128;
    localparam int CLEAR_AT_A     = 350;
    localparam int CLEAR_AT_B     = 700;
    localparam int HOLD_AT        = 500;
    localparam int HOLD_READS     = 48;
    localparam int DRAIN_AT       = 800;
    localparam int RX_HOLD_CYCLES = 600;
    localparam int TAIL_CYCLES    = 64;
    localparam int TIMEOUT_NS     = 48_000_000;

    localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd5;
    localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_CADENCE
    } t_rx_mode;

    logic                  clk           = 1'b0;
    logic                  rst_n         = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [KIND_W-1:0]     s_axis_tuser  = '0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    int                    fail_count;
    int                    reads_pending;
    int                    burst_left    = 0;
    int                    rx_hold_asked = 0;

    // 12 ns clock
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    clipped_fill_planar_framebuffer #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata)
    );

    cfpf_plane_checker #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) checker_i (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_reads_pending (reads_pending)
    );

    // full 16-bit signed value
    function automatic int any16();
        logic signed [15:0] v;
        v = 16'($urandom);
        return v;
    endfunction

    // coordinate biased to the top-left corner and the far border
    function automatic int pick_pos(int span);
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return int'($urandom_range(0, 47)) - 8;
        if (r < 70) return span - 24 + int'($urandom_range(0, 40));
        if (r < 90) return int'($urandom_range(0, span - 1));
        return any16();
    endfunction

    // small extent, zero and negative included
    function automatic int pick_small();
        return int'($urandom_range(0, 48)) - 8;
    endfunction

    // byte column: corner, right border, past the screen, anywhere
    function automatic int pick_bcol();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 5);
        if (r < 70) return $urandom_range(BYTE_COLS - 6, BYTE_COLS - 1);
        if (r < 85) return $urandom_range(BYTE_COLS, BCOL_MAX);
        return $urandom_range(0, BCOL_MAX);
    endfunction

    // offer one command, with a random gap at the start of each burst
    task automatic send(input logic [KIND_W-1:0] kind, input int x, input int y,
                        input int w, input int h, input int y_end, input int color,
                        input int plane, input int bcol);
        int gap;
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 160)
                                                     : $urandom_range(1, 16);
            gap = $urandom_range(0, 10);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {{(IN_DATA_W - IN_FIELDS){1'b0}}, BCOL_W'(bcol),
                          PLANE_W'(plane), COLOR_W'(color), 16'(y_end), 16'(h),
                          16'(w), 16'(y), 16'(x)};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // plane read aimed at the busy corner most of the time
    task automatic send_read();
        send(cfpf_pkg::K_READ, any16(), pick_pos(SCREEN_H), any16(), any16(), any16(),
             $urandom_range(0, 255), $urandom_range(0, 3), pick_bcol());
    endtask

    // stop offering until every read has returned
    task automatic wait_reads_done();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (reads_pending != 0) @(posedge clk);
    endtask

    // result side: random stall patterns, plus long hold-offs on request
    initial begin : rx_side
        int       hold_served;
        int       span;
        int       phase;
        t_rx_mode mode;
        hold_served = 0;
        phase = 0;
        forever begin
            if (rx_hold_asked != hold_served) begin
                hold_served++;
                @(posedge clk);
                m_axis_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end else begin
                mode = t_rx_mode'($urandom_range(0, 3));
                span = $urandom_range(8, 96);
                repeat (span) begin
                    @(posedge clk);
                    phase++;
                    case (mode)
                        RX_FREE:   m_axis_tready <= 1'b1;
                        RX_COIN:   m_axis_tready <= 1'($urandom_range(0, 1));
                        RX_SPARSE: m_axis_tready <= ($urandom_range(0, 3) == 0);
                        default:   m_axis_tready <= (phase % 3 != 0);
                    endcase
                end
            end
        end
    end

    // hard stop
    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

    // stimulus and verdict
    initial begin : stimulus
        int pick;
        int w;
        int h;
        int y0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // clear first so every later read sees written pixels; colour is masked
        send(cfpf_pkg::K_CLEAR, 0, 0, 0, 0, 0, 'hA3, 0, 0);
        send(cfpf_pkg::K_READ, 0, 0, 0, 0, 0, 0, 0, 0);
        send(cfpf_pkg::K_READ, 0, 0, 0, 0, 0, 0, 2, 0);

        // single pixels, on the corners and off screen
        send(cfpf_pkg::K_PIXEL, 0, 0, 0, 0, 0, 'hFF, 0, 0);
        send(cfpf_pkg::K_PIXEL, SCREEN_W - 1, SCREEN_H - 1, 0, 0, 0, 'h1C, 0, 0);
        send(cfpf_pkg::K_PIXEL, -1, 5, 0, 0, 0, 'hFF, 0, 0);
        send(cfpf_pkg::K_PIXEL, SCREEN_W, 0, 0, 0, 0, 'hFF, 0, 0);
        send(cfpf_pkg::K_PIXEL, 32767, -32768, -32768, 32767, -1, 'hFF, 3, BCOL_MAX);

        // rectangles: negative origin, far edge cut, empty and clipped away
        send(cfpf_pkg::K_RECT, -5, -3, 20, 10, 0, 'h06, 0, 0);
        send(cfpf_pkg::K_RECT, SCREEN_W - 10, SCREEN_H - 10, 32767, 32767, 0, 'h09,
             0, 0);
        send(cfpf_pkg::K_RECT, 4, 4, 0, 5, 0, 'h0F, 0, 0);
        send(cfpf_pkg::K_RECT, 4, 4, -32768, 5, 0, 'h0F, 0, 0);
        send(cfpf_pkg::K_RECT, -20, 2, 10, 4, 0, 'h0F, 0, 0);

        // column fills: clamped both ends, off screen, empty range
        send(cfpf_pkg::K_VLINE, 8, -10, 0, 0, 32767, 'hCC, 0, 0);
        send(cfpf_pkg::K_VLINE, -1, 0, 0, 0, 10, 'hFF, 0, 0);
        send(cfpf_pkg::K_VLINE, SCREEN_W, 0, 0, 0, 10, 'hFF, 0, 0);
        send(cfpf_pkg::K_VLINE, 12, 100, 0, 0, 100, 'hFF, 0, 0);

        // unused kinds do nothing
        send(KIND_SPARE_LO, 0, 0, 100, 100, 100, 'hFF, 1, 0);
        send(KIND_SPARE_HI, -1, -1, -1, -1, -1, 'hFF, 3, BCOL_MAX);

        // reads inside, on the border and out of range
        send(cfpf_pkg::K_READ, 0, 0, 0, 0, 0, 0, 3, 0);
        send(cfpf_pkg::K_READ, 0, 6, 0, 0, 0, 0, 1, 0);
        send(cfpf_pkg::K_READ, 0, 200, 0, 0, 0, 0, 2, 1);
        send(cfpf_pkg::K_READ, 0, SCREEN_H - 1, 0, 0, 0, 0, 0, BYTE_COLS - 1);
        send(cfpf_pkg::K_READ, 0, -1, 0, 0, 0, 0, 0, 0);
        send(cfpf_pkg::K_READ, 0, SCREEN_H, 0, 0, 0, 0, 0, 0);
        send(cfpf_pkg::K_READ, 0, 0, 0, 0, 0, 0, 0, BYTE_COLS);
        send(cfpf_pkg::K_READ, 0, 0, 0, 0, 0, 0, 3, BCOL_MAX);

        // random mix, mostly around the corner where reads look
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (n == CLEAR_AT_A || n == CLEAR_AT_B) begin
                send(cfpf_pkg::K_CLEAR, any16(), any16(), any16(), any16(), any16(),
                     $urandom_range(0, 255), $urandom_range(0, 3),
                     $urandom_range(0, BCOL_MAX));
            end else if (n % BIG_FILL_EVERY == BIG_FILL_EVERY / 2) begin
                // a few large rectangles, most of the screen at worst
                send(cfpf_pkg::K_RECT, int'($urandom_range(0, 150)) - 50,
                     int'($urandom_range(0, 150)) - 50, $urandom_range(0, 700),
                     $urandom_range(0, 520), any16(), $urandom_range(0, 255),
                     $urandom_range(0, 3), $urandom_range(0, BCOL_MAX));
            end else if (pick < 20) begin
                send(cfpf_pkg::K_PIXEL, pick_pos(SCREEN_W), pick_pos(SCREEN_H),
                     any16(), any16(), any16(), $urandom_range(0, 255),
                     $urandom_range(0, 3), $urandom_range(0, BCOL_MAX));
            end else if (pick < 46) begin
                // only one side may be huge, so a fill stays a few rows or columns
                w = pick_small();
                h = pick_small();
                if (pick < 23)
                    w = any16();
                else if (pick < 26)
                    h = any16();
                send(cfpf_pkg::K_RECT, pick_pos(SCREEN_W), pick_pos(SCREEN_H), w, h,
                     any16(), $urandom_range(0, 255), $urandom_range(0, 3),
                     $urandom_range(0, BCOL_MAX));
            end else if (pick < 62) begin
                y0 = pick_pos(SCREEN_H);
                send(cfpf_pkg::K_VLINE, pick_pos(SCREEN_W), y0, any16(), any16(),
                     ($urandom_range(0, 5) == 0) ? any16()
                                                 : y0 + int'($urandom_range(0, 70)) - 10,
                     $urandom_range(0, 255), $urandom_range(0, 3),
                     $urandom_range(0, BCOL_MAX));
            end else if (pick < 97) begin
                send_read();
            end else begin
                send(KIND_W'($urandom_range(KIND_SPARE_LO, KIND_SPARE_HI)),
                     any16(), any16(), any16(), any16(), any16(), $urandom_range(0, 255),
                     $urandom_range(0, 3), $urandom_range(0, BCOL_MAX));
            end

            // result side holds off while reads keep coming, so input backs up
            if (n == HOLD_AT) begin
                rx_hold_asked <= rx_hold_asked + 1;
                burst_left = HOLD_READS;
                repeat (HOLD_READS) send_read();
            end

            // pause until every read has returned
            if (n == DRAIN_AT) wait_reads_done();
        end

        // closing reads come after every fill in the command order
        repeat (8) send_read();
        wait_reads_done();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
